### design/ahfd_pkg.sv
// Shared types and constants for the ASCII hex frame decoder.
// No dependencies; imported by every module of the decoder except ahfd_checker.
`default_nettype none

package ahfd_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int          CAP_W       = 16;
    localparam int          COUNT_W     = 17;
    localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
    localparam logic [7:0]  ID_LAST_LOW = 8'd100;
    localparam logic [7:0]  ID_EXTRA    = 8'd120;
    localparam logic [15:0] CAP_RESET   = 16'd256;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_DATA_W = 32;

    typedef enum logic [2:0] {
        TK_COLON,
        TK_CR,
        TK_LF,
        TK_HEX,
        TK_BAD
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [3:0] nib;
    } t_token;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_BAD_CHAR = 3'd2,
        ST_SHORT    = 3'd3,
        ST_TOO_LONG = 3'd4
    } t_status;

    typedef enum logic {
        FS_IDLE,
        FS_FRAME
    } t_frame_state;

    // Result beat as it leaves the back end.
    typedef struct packed {
        logic       frame_end;
        logic [7:0] data_byte;
        logic [7:0] dest_id;
        logic [7:0] command;
        logic       id_known;
        t_status    status;
    } t_result;

endpackage

`default_nettype wire

### design/ahfd_front.sv
// Front end: accepts characters and classifies them into tokens.
// Depends on ahfd_pkg; feeds ahfd_queue.
`default_nettype none

module ahfd_front (
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_queue_full,
    output logic               o_push,
    output ahfd_pkg::t_token   o_token
);
    import ahfd_pkg::*;

    logic [3:0] nib;
    logic       is_hex;

    always_comb begin
        is_hex = 1'b1;
        nib    = 4'd0;
        if (i_char >= 8'h30 && i_char <= 8'h39) begin
            nib = 4'(i_char - 8'h30);
        end else if (i_char >= 8'h41 && i_char <= 8'h46) begin
            nib = 4'(i_char - 8'h37);
        end else if (i_char >= 8'h61 && i_char <= 8'h66) begin
            nib = 4'(i_char - 8'h57);
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        o_token.nib = nib;
        priority if (i_char == CH_COLON) begin
            o_token.kind = TK_COLON;
        end else if (i_char == CH_CR) begin
            o_token.kind = TK_CR;
        end else if (i_char == CH_LF) begin
            o_token.kind = TK_LF;
        end else if (is_hex) begin
            o_token.kind = TK_HEX;
        end else begin
            o_token.kind = TK_BAD;
        end
    end

    assign o_ready = !i_queue_full;
    // CR never changes frame state, so it is dropped here
    assign o_push  = i_valid && !i_queue_full && (o_token.kind != TK_CR);

endmodule

`default_nettype wire

### design/ahfd_queue.sv
// Short token queue between front and back ends.
// Depends on ahfd_pkg for the token type and depth.
`default_nettype none

module ahfd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ahfd_pkg::t_token i_token,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output ahfd_pkg::t_token   o_token
);
    import ahfd_pkg::*;

    t_token              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

`default_nettype wire

### design/ahfd_back.sv
// Back end: frame tracking, byte assembly, checksum, payload hold-back
// and end-of-frame status. Depends on ahfd_pkg; drains ahfd_queue.
`default_nettype none

module ahfd_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [ahfd_pkg::CAP_W-1:0] i_capacity,
    input  wire logic                       i_tok_valid,
    input  wire ahfd_pkg::t_token           i_token,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output ahfd_pkg::t_result               o_result
);
    import ahfd_pkg::*;

    t_frame_state        r_state, n_state;
    logic                r_have_hi, n_have_hi;
    logic [3:0]          r_hi, n_hi;
    logic [7:0]          r_sum, n_sum;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [7:0]          r_held, n_held;
    logic [7:0]          r_id, n_id;
    logic [7:0]          r_cmd, n_cmd;
    logic                r_bad, n_bad;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic [7:0]          byte_val;
    logic [COUNT_W:0]    long_limit;
    logic                too_long;
    t_status             status;

    // a token is taken only when the result register is free or being drained this cycle
    assign o_pop = i_tok_valid && (!r_out_valid || i_ready);

    assign byte_val   = {r_hi, i_token.nib};
    assign long_limit = (COUNT_W+1)'(i_capacity) + (COUNT_W+1)'(3);
    assign too_long   = ({1'b0, r_count} >= long_limit);

    always_comb begin
        priority if (r_bad || r_have_hi) begin
            status = ST_BAD_CHAR;
        end else if (r_count < COUNT_W'(3)) begin
            status = ST_SHORT;
        end else if (too_long) begin
            status = ST_TOO_LONG;
        end else if (r_sum != 8'd0) begin
            status = ST_CHECKSUM;
        end else begin
            status = ST_OK;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (o_pop) begin
            if (i_token.kind == TK_COLON) begin
                n_state = FS_FRAME;
            end else if (r_state == FS_FRAME && i_token.kind == TK_LF) begin
                n_state = FS_IDLE;
            end
        end
    end

    // datapath and result
    always_comb begin
        n_have_hi   = r_have_hi;
        n_hi        = r_hi;
        n_sum       = r_sum;
        n_count     = r_count;
        n_held      = r_held;
        n_id        = r_id;
        n_cmd       = r_cmd;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;

        if (o_pop) begin
            if (i_token.kind == TK_COLON) begin
                n_have_hi = 1'b0;
                n_hi      = 4'd0;
                n_sum     = 8'd0;
                n_count   = '0;
                n_held    = 8'd0;
                n_id      = 8'd0;
                n_cmd     = 8'd0;
                n_bad     = 1'b0;
            end else if (r_state == FS_FRAME) begin
                unique case (i_token.kind)
                    TK_LF: begin
                        n_out_valid        = 1'b1;
                        n_out.frame_end    = 1'b1;
                        n_out.data_byte    = 8'd0;
                        n_out.dest_id      = r_id;
                        n_out.command      = r_cmd;
                        n_out.id_known     = (r_id <= ID_LAST_LOW) || (r_id == ID_EXTRA);
                        n_out.status       = status;
                    end
                    TK_BAD: begin
                        n_bad = 1'b1;
                    end
                    TK_HEX: begin
                        if (!r_have_hi) begin
                            n_hi      = i_token.nib;
                            n_have_hi = 1'b1;
                        end else begin
                            n_have_hi = 1'b0;
                            n_sum     = r_sum + byte_val;
                            if (r_count == COUNT_W'(0)) begin
                                n_id = byte_val;
                            end else if (r_count == COUNT_W'(1)) begin
                                n_cmd = byte_val;
                            end else begin
                                // release the previous payload byte one byte late
                                if (r_count >= COUNT_W'(3)) begin
                                    n_out_valid     = 1'b1;
                                    n_out.frame_end = 1'b0;
                                    n_out.data_byte = r_held;
                                    n_out.dest_id   = 8'd0;
                                    n_out.command   = 8'd0;
                                    n_out.id_known  = 1'b0;
                                    n_out.status    = ST_OK;
                                end
                                n_held = byte_val;
                            end
                            if (r_count != COUNT_MAX) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                    default: begin
                        // colon handled above; CR carries no work
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_IDLE;
            r_have_hi   <= 1'b0;
            r_hi        <= 4'd0;
            r_sum       <= 8'd0;
            r_count     <= '0;
            r_held      <= 8'd0;
            r_id        <= 8'd0;
            r_cmd       <= 8'd0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_hi   <= n_have_hi;
            r_hi        <= n_hi;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_held      <= n_held;
            r_id        <= n_id;
            r_cmd       <= n_cmd;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

### design/ascii_hex_frame_decoder.sv
// Top level of the ASCII hex frame decoder: capacity register, front end,
// token queue and back end. Depends on ahfd_pkg, ahfd_front, ahfd_queue, ahfd_back.
//
//   channel   | handshake                      | payload
//   ----------+--------------------------------+-----------------------------------
//   char in   | s_axis_tvalid / s_axis_tready  | s_axis_tdata = rx_char
//   result    | m_axis_tvalid / m_axis_tready  | m_axis_tdata, m_axis_tlast = frame_end
//   config    | i_cfg_valid / o_cfg_ready      | i_cfg_data = out_capacity
//
// One character per cycle is accepted while the token queue has room; one token
// per cycle leaves the queue while the result register is free or being drained.
// Between character beat and result beat lie the token queue and the result register.
// Reset (i_rst_n low, synchronous) empties the queue, drops any frame in progress
// and sets out_capacity to 256. A stalled result beat holds the back end; the
// two-entry queue keeps taking characters until it is full.
`default_nettype none

module ascii_hex_frame_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_char

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] data_byte, [15:8] dest_id,
                                             // [23:16] command, [24] id_known,
                                             // [27:25] status, [31:28] zero
    output logic             m_axis_tlast,   // frame_end: status beat

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data      // out_capacity
);
    import ahfd_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             q_full;
    logic             push;
    t_token           front_tok;
    logic             q_valid;
    t_token           q_tok;
    logic             pop;
    t_result          result;

    // user rule, unchecked: capacity is rewritten only while the decoder is idle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    ahfd_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_char       (s_axis_tdata),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_token      (front_tok)
    );

    ahfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (front_tok),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_token (q_tok)
    );

    ahfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_tok_valid (q_valid),
        .i_token     (q_tok),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tlast = result.frame_end;
    assign m_axis_tdata = {4'd0, result.status, result.id_known,
                           result.command, result.dest_id, result.data_byte};

endmodule

`default_nettype wire

### design/ahfd_checker.sv
// Port-level checks for the ASCII hex frame decoder, bound to the top level.
// Depends on ascii_hex_frame_decoder's port list.
`default_nettype none

module ahfd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // payload beat carries only the data byte
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[31:8] == 24'd0)
        else $error("payload beat carries status fields");

    // status beat: no data byte, status in range
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[31:28] == 4'd0 &&
            m_axis_tdata[27:25] != 3'd5 && m_axis_tdata[27:25] != 3'd6 &&
            m_axis_tdata[27:25] != 3'd7)
        else $error("bad status beat");

    // id_known matches dest_id
    a_id_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[24] == ((m_axis_tdata[15:8] <= 8'd100) ||
                                 (m_axis_tdata[15:8] == 8'd120)))
        else $error("id_known disagrees with dest_id");

endmodule

bind ascii_hex_frame_decoder ahfd_checker u_ahfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### tb/ahfd_frame_checker.sv
// Scoreboard for the ASCII hex frame decoder: watches the character, capacity and
// result channels, predicts every result beat and compares it with the DUT.
// Depends on ahfd_pkg.
module ahfd_frame_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_char_valid,
    input  wire logic        i_char_ready,
    input  wire logic [7:0]  i_char,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [31:0] i_res_data,
    input  wire logic        i_res_last,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    output int               o_mismatches,
    output int               o_outstanding
);
    import ahfd_pkg::*;

    localparam logic [COUNT_W-1:0] MIN_FRAME_BYTES = COUNT_W'(3);   // id, command, checksum

    logic [CAP_W-1:0]   capacity;
    logic               frame_open;
    logic               hi_valid;
    logic [3:0]         hi_nib;
    logic [7:0]         byte_sum;
    logic [COUNT_W-1:0] byte_cnt;
    logic [7:0]         held_payload;
    logic [7:0]         frame_id;
    logic [7:0]         frame_cmd;
    logic               char_error;
    t_result            expected_results[$];
    int                 mismatch_cnt = 0;

    task automatic clear_frame();
        hi_valid     = 1'b0;
        hi_nib       = '0;
        byte_sum     = '0;
        byte_cnt     = '0;
        held_payload = '0;
        frame_id     = '0;
        frame_cmd    = '0;
        char_error   = 1'b0;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_result    want;
        t_result    got;
        logic [7:0] ch;
        logic [7:0] value;
        logic       is_hex;

        if (!i_rst_n) begin
            capacity   = CAP_RESET;
            frame_open = 1'b0;
            clear_frame();
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                capacity = i_cfg_data;

            // result side first: a beat leaving now belongs to an earlier character
            if (i_res_valid && i_res_ready) begin
                got.frame_end = i_res_last;
                got.data_byte = i_res_data[7:0];
                got.dest_id   = i_res_data[15:8];
                got.command   = i_res_data[23:16];
                got.id_known  = i_res_data[24];
                got.status    = t_status'(i_res_data[27:25]);
                if (expected_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected result beat, tlast=%b tdata=%h",
                                 $time, i_res_last, i_res_data);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || i_res_data[31:28] !== 4'h0) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected end=%b data=%h id=%h cmd=%h known=%b st=%0d pad=0",
                                     want.frame_end, want.data_byte, want.dest_id,
                                     want.command, want.id_known, want.status);
                            $display("  actual   end=%b data=%h id=%h cmd=%h known=%b st=%0d pad=%h",
                                     got.frame_end, got.data_byte, got.dest_id,
                                     got.command, got.id_known, got.status,
                                     i_res_data[31:28]);
                        end
                    end
                end
            end

            if (i_char_valid && i_char_ready) begin
                ch     = i_char;
                is_hex = 1'b1;
                if (ch >= "0" && ch <= "9")
                    value = ch - "0";
                else if (ch >= "A" && ch <= "F")
                    value = ch - "A" + 8'd10;
                else if (ch >= "a" && ch <= "f")
                    value = ch - "a" + 8'd10;
                else begin
                    value  = '0;
                    is_hex = 1'b0;
                end

                if (ch == CH_COLON) begin
                    frame_open = 1'b1;
                    clear_frame();
                end else if (frame_open && ch != CH_CR) begin
                    if (ch == CH_LF) begin
                        want           = '0;
                        want.frame_end = 1'b1;
                        want.dest_id   = frame_id;
                        want.command   = frame_cmd;
                        want.id_known  = (frame_id <= ID_LAST_LOW) || (frame_id == ID_EXTRA);
                        if (char_error || hi_valid)
                            want.status = ST_BAD_CHAR;
                        else if (byte_cnt < MIN_FRAME_BYTES)
                            want.status = ST_SHORT;
                        else if (byte_cnt - MIN_FRAME_BYTES >= {1'b0, capacity})
                            want.status = ST_TOO_LONG;
                        else if (byte_sum != 8'h00)
                            want.status = ST_CHECKSUM;
                        else
                            want.status = ST_OK;
                        expected_results.push_back(want);
                        frame_open = 1'b0;
                    end else if (!is_hex) begin
                        char_error = 1'b1;
                    end else if (!hi_valid) begin
                        hi_nib   = value[3:0];
                        hi_valid = 1'b1;
                    end else begin
                        hi_valid = 1'b0;
                        value    = {hi_nib, value[3:0]};
                        byte_sum = byte_sum + value;
                        if (byte_cnt == 0)
                            frame_id = value;
                        else if (byte_cnt == 1)
                            frame_cmd = value;
                        else begin
                            // payload runs one byte behind, so the checksum never leaks out
                            if (byte_cnt >= MIN_FRAME_BYTES) begin
                                want           = '0;
                                want.data_byte = held_payload;
                                expected_results.push_back(want);
                            end
                            held_payload = value;
                        end
                        if (byte_cnt != COUNT_MAX)
                            byte_cnt = byte_cnt + 1'b1;
                    end
                end
            end
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= expected_results.size();
    end

endmodule

### tb/tb_ascii_hex_frame_decoder.sv
// Testbench top for the ASCII hex frame decoder: drives character beats, capacity
// writes and result back-pressure, and gives the verdict.
// Depends on ahfd_pkg, ascii_hex_frame_decoder and ahfd_frame_checker.
module tb_ascii_hex_frame_decoder;
    import ahfd_pkg::*;

    localparam int SETTLE_CYCLES = 8;     // lets tokens that make no beat clear the pipe
    localparam int TAIL_CYCLES   = 16;    // catches stray beats after the last expected one
    localparam int QUIET_LIMIT   = 2000;  // far above any legal stall, gap or settle
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_CHARS   = 250;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;      // [7:0] rx_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [7:0] data_byte, [15:8] dest_id, [23:16] command,
                                          // [24] id_known, [27:25] status, [31:28] zero
    logic        m_axis_tlast;            // frame_end
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data    = '0;      // out_capacity

    int          mismatches;
    int          outstanding;
    logic        send_gaps     = 1'b1;    // random holes in the character stream
    logic        recv_stalls   = 1'b1;    // random back-pressure on the result stream
    int unsigned chars_sent    = 0;
    int unsigned quiet_cycles  = 0;
    logic [7:0]  frame_payload[$];        // payload of the next frame to build
    logic [7:0]  char_line[$];            // characters waiting to be sent

    ascii_hex_frame_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    ahfd_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_valid  (s_axis_tvalid),
        .i_char_ready  (s_axis_tready),
        .i_char        (s_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_last    (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Result side: ready is high except in random stall bursts.
    initial begin : result_pacing
        forever begin
            if (recv_stalls && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, outstanding);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One character beat; an optional idle burst goes in front of it.
    task automatic send_char(input logic [7:0] ch);
        if (send_gaps && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++)
            send_char(text[k]);
    endtask

    task automatic send_line();
        foreach (char_line[k])
            send_char(char_line[k]);
        char_line.delete();
    endtask

    // Hold the sender until every predicted beat has come back, then let the
    // pipe empty of characters that produce no beat.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
        if (nib < 4'd10)
            return "0" + nib;
        return (lower ? "a" : "A") + nib - 8'd10;
    endfunction

    task automatic add_byte(input logic [7:0] value, input logic lower);
        char_line.push_back(hex_char(value[7:4], lower));
        char_line.push_back(hex_char(value[3:0], lower));
    endtask

    // Biased toward the byte extremes.
    function automatic logic [7:0] rand_byte();
        logic [7:0] value;
        case ($urandom_range(0, 7))
            0:       value = 8'h00;
            1:       value = 8'hFF;
            default: value = 8'($urandom);
        endcase
        return value;
    endfunction

    // Ids spread over the known range, its edges and the unknown range.
    function automatic logic [7:0] pick_id();
        logic [7:0] id;
        case ($urandom_range(0, 3))
            0:       id = 8'($urandom_range(0, ID_LAST_LOW));
            1:       id = 8'(($urandom_range(0, 1) ? ID_LAST_LOW : ID_EXTRA)
                             + $urandom_range(0, 2) - 1);
            2:       id = 8'($urandom_range(ID_LAST_LOW + 1, 255));
            default: id = 8'($urandom);
        endcase
        return id;
    endfunction

    // Appends ':' id cmd payload checksum [CR] LF to the line.
    task automatic build_frame(input logic [7:0] id, input logic [7:0] cmd,
                               input logic good_sum, input logic lower, input logic with_cr);
        logic [7:0] sum;
        logic [7:0] check;
        logic [7:0] offset;
        sum = id + cmd;
        char_line.push_back(CH_COLON);
        add_byte(id, lower);
        add_byte(cmd, lower);
        foreach (frame_payload[k]) begin
            add_byte(frame_payload[k], lower);
            sum = sum + frame_payload[k];
        end
        check = 8'h00 - sum;
        if (!good_sum) begin
            offset = 8'($urandom_range(1, 255));
            check  = check + offset;
        end
        add_byte(check, lower);
        if (with_cr)
            char_line.push_back(CH_CR);
        char_line.push_back(CH_LF);
    endtask

    // Mostly well-formed frames with random content; the rest is line noise,
    // runts and frames broken by one edit.
    task automatic random_frame();
        int unsigned n_bytes;
        int unsigned pos;
        logic        lower;
        logic [7:0]  junk;
        lower = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) char_line.push_back(rand_byte());
        if ($urandom_range(0, 15) == 0) begin
            char_line.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) add_byte(rand_byte(), lower);
            char_line.push_back(CH_LF);
        end else begin
            frame_payload.delete();
            n_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            repeat (n_bytes) frame_payload.push_back(rand_byte());
            build_frame(pick_id(), rand_byte(), $urandom_range(0, 7) != 0, lower,
                        1'($urandom_range(0, 1)));
            pos  = $urandom_range(1, char_line.size() - 1);
            junk = 8'("G" + $urandom_range(0, 19));
            case ($urandom_range(0, 15))
                0:       char_line.insert(pos, rand_byte());
                1:       char_line.insert(pos, junk);
                2:       char_line.delete(pos);                  // odd digit count or lost LF
                3:       char_line.insert(pos, CH_COLON);        // restart mid-frame
                4:       char_line.insert(pos, CH_CR);
                5:       char_line.delete(char_line.size() - 1); // runs into the next frame
                default: ;
            endcase
        end
        send_line();
    endtask

    task automatic long_frame(input int unsigned n_payload);
        frame_payload.delete();
        repeat (n_payload) frame_payload.push_back(8'($urandom));
        build_frame(pick_id(), rand_byte(), 1'b1, 1'b0, 1'b0);
        send_line();
    endtask

    initial begin : stimulus
        int unsigned mid_mark;
        int unsigned phase_end;
        logic        paused;
        logic [15:0] cap;

        paused = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed, reset capacity ----
        send_char("Z");                           // nothing open yet: all ignored
        send_char(8'hFF);
        send_char(CH_LF);
        send_text(":12");                         // abandoned by the next colon
        frame_payload.push_back(8'h00);
        frame_payload.push_back(8'hFF);
        build_frame(ID_EXTRA, 8'hFF, 1'b1, 1'b1, 1'b1);   // lowercase, CR, good sum
        frame_payload.delete();
        build_frame(ID_LAST_LOW + 8'd1, 8'h00, 1'b0, 1'b0, 1'b0);  // bare frame, bad sum
        send_line();
        send_text(":05");                         // one byte only
        send_char(CH_LF);
        send_text(":0@5");                        // non-hex digits flag a bad character, pairing goes on
        send_char(8'h60);
        send_text("0/0");
        send_char(CH_LF);
        send_text(":123");                        // odd digit count
        send_char(CH_LF);
        send_text(":1");                          // odd count outranks runt
        send_char(CH_LF);

        // ---- capacity zero: nothing fits ----
        write_capacity(16'd0);
        build_frame(ID_LAST_LOW, 8'h01, 1'b1, 1'b0, 1'b0);
        build_frame(8'h00, 8'h02, 1'b0, 1'b0, 1'b0);      // overflow outranks checksum
        send_line();
        send_text(":00");                          // runt outranks overflow
        send_char(CH_LF);

        // ---- maximum capacity, a long payload streamed flat out ----
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        write_capacity(16'hFFFF);
        long_frame(48);

        // ---- random phases over several capacities ----
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       cap = 16'd1;
                1:       cap = 16'd3;
                2:       cap = 16'($urandom_range(2, 12));
                3:       cap = 16'hFFFF;
                4:       cap = 16'($urandom_range(0, 40));
                default: cap = CAP_RESET;
            endcase
            write_capacity(cap);
            // quiet stretches on each side; phase 2 sends and phase 3 receives flat out, the last phase runs flat out
            send_gaps   = (p != 2) && (p != RANDOM_PHASES - 1);
            recv_stalls = (p != 3) && (p != RANDOM_PHASES - 1);
            mid_mark    = chars_sent + PHASE_CHARS / 2;
            phase_end   = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end) begin
                random_frame();
                if (p == 1 && !paused && chars_sent >= mid_mark) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
